/* sv/assert_macros.svh */
// Assertion macros for the checker file of the limiter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define PLRE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, ignored while reset is asserted.
`define PLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/plre_pkg.sv */
// Shared types and constants for the peak limiter with release envelope.
// No dependencies; used by the controller, the datapath and the top level.
package plre_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEFF_WIDTH  = 16;
    localparam int THR_WIDTH    = SAMPLE_WIDTH - 1;
    localparam int CFG_WIDTH    = (THR_WIDTH > COEFF_WIDTH) ? THR_WIDTH : COEFF_WIDTH;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int NUM_WIDTH    = SAMPLE_WIDTH + THR_WIDTH;
    localparam int CNT_WIDTH    = $clog2(THR_WIDTH);
    localparam int TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic [THR_WIDTH-1:0]   THR_RESET   = THR_WIDTH'(1048576);
    localparam logic [COEFF_WIDTH-1:0] COEFF_RESET = COEFF_WIDTH'(65522);

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_RELEASE   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_ENV,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mag;
        logic env;
        logic mul;
        logic div;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic limit;
    } t_status;

endpackage

/* sv/plre_ctrl.sv */
// Sequencing controller of the limiter: steps one item through magnitude,
// envelope update, scaling product and, when the envelope limits, the restoring divider.
// Depends on plre_pkg.
module plre_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  plre_pkg::t_status   i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output plre_pkg::t_cmd      o_cmd
);

    plre_pkg::t_state                  r_state;
    plre_pkg::t_state                  n_state;
    logic [plre_pkg::CNT_WIDTH-1:0]    r_cnt;
    logic [plre_pkg::CNT_WIDTH-1:0]    n_cnt;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic                              out_free;

    // The output register may be refilled when empty or being drained this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            plre_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = plre_pkg::S_MAG;
                end
            end
            plre_pkg::S_MAG: begin
                n_state = plre_pkg::S_ENV;
            end
            plre_pkg::S_ENV: begin
                n_state = plre_pkg::S_MUL;
            end
            plre_pkg::S_MUL: begin
                if (i_status.limit) begin
                    n_state = plre_pkg::S_DIV;
                    n_cnt   = plre_pkg::CNT_WIDTH'(plre_pkg::THR_WIDTH - 1);
                end else begin
                    n_state = plre_pkg::S_DONE;
                end
            end
            plre_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = plre_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            plre_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = plre_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plre_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            plre_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_in  = i_in_valid;
            end
            plre_pkg::S_MAG: begin
                o_cmd.mag = 1'b1;
            end
            plre_pkg::S_ENV: begin
                o_cmd.env = 1'b1;
            end
            plre_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            plre_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
            end
            plre_pkg::S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plre_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/plre_dp.sv */
// Datapath of the limiter: configuration registers, envelope state, the two
// multipliers, a one-bit-per-cycle restoring divider and the output register.
// Depends on plre_pkg; driven by plre_ctrl.
module plre_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_addr,
    input  logic [plre_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  logic [plre_pkg::SAMPLE_WIDTH-1:0]    i_sample,
    input  logic                                 i_first,
    input  plre_pkg::t_cmd                       i_cmd,
    output plre_pkg::t_status                    o_status,
    output logic [plre_pkg::SAMPLE_WIDTH-1:0]    o_sample,
    output logic                                 o_engaged
);

    localparam int SW = plre_pkg::SAMPLE_WIDTH;
    localparam int TW = plre_pkg::THR_WIDTH;
    localparam int CW = plre_pkg::COEFF_WIDTH;

    logic [TW-1:0]                       r_thr;
    logic [CW-1:0]                       r_coeff;
    logic [SW-1:0]                       r_raw;
    logic                                r_first;
    logic [SW-1:0]                       r_mag;
    logic [plre_pkg::PROD_WIDTH-1:0]     r_prod;
    logic [SW-1:0]                       r_env;
    logic                                r_flag;
    logic                                r_lim;
    logic [SW-1:0]                       r_rem;
    logic [TW-1:0]                       r_quo;
    logic [SW-1:0]                       r_out;
    logic                                r_out_eng;

    logic                                neg_raw;
    logic [SW-1:0]                       mag_raw;
    logic [SW-1:0]                       env_eff;
    logic [plre_pkg::PROD_WIDTH-1:0]     prod;
    logic                                above;
    logic [plre_pkg::NUM_WIDTH-1:0]      num;
    logic [SW:0]                         shifted;
    logic [SW:0]                         diff;
    logic                                take;
    logic [SW-1:0]                       quo_ext;
    logic [SW-1:0]                       limited;

    assign neg_raw = r_raw[SW-1];
    assign mag_raw = neg_raw ? (~r_raw + 1'b1) : r_raw;
    assign env_eff = r_first ? '0 : r_env;
    assign prod    = env_eff * r_coeff;
    assign above   = r_mag > {1'b0, r_thr};
    assign num     = r_mag * r_thr;

    // Restoring division: the quotient never exceeds the threshold, so the
    // upper dividend bits start below the divisor and one bit settles per cycle.
    assign shifted = {r_rem, r_quo[TW-1]};
    assign diff    = shifted - {1'b0, r_env};
    assign take    = shifted >= {1'b0, r_env};

    assign quo_ext = {1'b0, r_quo};
    assign limited = neg_raw ? (~quo_ext + 1'b1) : quo_ext;

    assign o_status.limit = r_env > {1'b0, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= plre_pkg::THR_RESET;
            r_coeff <= plre_pkg::COEFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                plre_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data[TW-1:0];
                plre_pkg::CFG_RELEASE:   r_coeff <= i_cfg_data[CW-1:0];
                default: begin
                    r_thr <= r_thr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_flag <= 1'b0;
        end else if (i_cmd.env) begin
            if (above) begin
                r_env <= r_mag;
            end else begin
                r_env <= r_prod[plre_pkg::PROD_WIDTH-1:CW];
            end
            r_flag <= (r_flag && !r_first) || above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw   <= i_sample;
            r_first <= i_first;
        end
        if (i_cmd.mag) begin
            r_mag  <= mag_raw;
            r_prod <= prod;
        end
        if (i_cmd.mul) begin
            r_lim <= o_status.limit;
            r_rem <= num[plre_pkg::NUM_WIDTH-1:TW];
            r_quo <= num[TW-1:0];
        end else if (i_cmd.div) begin
            if (take) begin
                r_rem <= diff[SW-1:0];
            end else begin
                r_rem <= shifted[SW-1:0];
            end
            r_quo <= {r_quo[TW-2:0], take};
        end
        if (i_cmd.out_load) begin
            r_out     <= r_lim ? limited : r_raw;
            r_out_eng <= r_flag;
        end
    end

    assign o_sample  = r_out;
    assign o_engaged = r_out_eng;

endmodule

/* sv/peak_limiter_release_envelope.sv */
// Peak limiter, instant attack and exponential release: top level.
// An item passes the magnitude, envelope and product states when the envelope is at
// or below the threshold, and also the 23-step divider when it limits.
// One item is in work at a time, till the output register takes its result.
// The finished result waits in an output register; the next item may enter meanwhile.
// Synchronous active-low reset restores the register defaults, clears the envelope.
module peak_limiter_release_envelope (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_addr,
    input  logic [plre_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [plre_pkg::TDATA_WIDTH-1:0]      s_axis_tdata,  // [23:0] sample_in
    input  logic                                  s_axis_tuser,  // [0] first
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [plre_pkg::TDATA_WIDTH-1:0]      m_axis_tdata,  // [23:0] sample_out
    output logic                                  m_axis_tuser   // [0] engaged
);

    plre_pkg::t_cmd                        cmd;
    plre_pkg::t_status                     status;
    logic [plre_pkg::SAMPLE_WIDTH-1:0]     sample_out;

    plre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    plre_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata[plre_pkg::SAMPLE_WIDTH-1:0]),
        .i_first    (s_axis_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_sample   (sample_out),
        .o_engaged  (m_axis_tuser)
    );

    assign m_axis_tdata = plre_pkg::TDATA_WIDTH'(sample_out);

endmodule

/* sv/plre_checker.sv */
// Port-level checker for the limiter, bound to the top level.
// Depends on plre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plre_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [plre_pkg::TDATA_WIDTH-1:0]      m_axis_tdata,
    input  logic                                  m_axis_tuser
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result must hold its value.
    `PLRE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Only one item is in work, so the input closes right after an item enters.
    `PLRE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_acc, !s_axis_tready, "input still open after an item was taken")

    // A result cannot appear in the cycle after its item entered.
    `PLRE_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, in_acc && !m_axis_tvalid, !m_axis_tvalid, "result appeared too early")

    // Delivering a result returns the block to waiting for input.
    `PLRE_ASSERT(a_ready_after, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> s_axis_tready, "input not reopened when result appeared")

endmodule

bind peak_limiter_release_envelope plre_checker u_plre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/testbench.sv */
// Self-checking bench for the peak limiter: stream driver, stream monitor and a predictor.
// The predictor keeps its own envelope, engaged flag and register copies.
// Depends on plre_pkg and peak_limiter_release_envelope.
module testbench;

    typedef struct packed {
        logic [plre_pkg::SAMPLE_WIDTH-1:0] sample;
        logic                              first;
    } t_sample_item;

    typedef struct packed {
        logic [plre_pkg::SAMPLE_WIDTH-1:0] sample;
        logic                              engaged;
    } t_limited;

    localparam int unsigned FULL_POS = 8388607;
    localparam int unsigned FULL_MAG = 8388608;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASE_ITEMS = 235;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic                                 i_cfg_addr = plre_pkg::CFG_THRESHOLD;
    logic [plre_pkg::CFG_WIDTH-1:0]       i_cfg_data = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [plre_pkg::TDATA_WIDTH-1:0]     s_axis_tdata = '0;   // [23:0] sample_in
    logic                                 s_axis_tuser = 1'b0; // [0] first
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [plre_pkg::TDATA_WIDTH-1:0]     m_axis_tdata;        // [23:0] sample_out
    logic                                 m_axis_tuser;        // [0] engaged

    // Predictor state and its copy of the registers.
    logic [plre_pkg::SAMPLE_WIDTH-1:0]    env_mag;
    logic                                 engaged_st;
    logic [plre_pkg::THR_WIDTH-1:0]       thr_cfg;
    logic [plre_pkg::COEFF_WIDTH-1:0]     coeff_cfg;

    t_sample_item samples_to_send[$];
    t_limited     limited_pending[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatch_count = 0;
    bit          in_fire = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_ack = 1'b0;
    int          hold_left = 0;

    peak_limiter_release_envelope dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Instant attack, truncated exponential release, then gain by threshold over envelope.
    function automatic t_limited limit_sample(input logic [plre_pkg::SAMPLE_WIDTH-1:0] raw,
                                              input logic first);
        logic                              neg;
        logic [plre_pkg::SAMPLE_WIDTH-1:0] mag;
        logic [plre_pkg::SAMPLE_WIDTH-1:0] quot;
        logic [47:0]                       prod;
        t_limited                          res;
        neg = raw[plre_pkg::SAMPLE_WIDTH-1];
        mag = neg ? (~raw + 1'b1) : raw;
        res.sample = raw;
        if (first) begin
            env_mag = '0;
            engaged_st = 1'b0;
        end
        if (mag > {1'b0, thr_cfg}) begin
            env_mag = mag;
            engaged_st = 1'b1;
        end else begin
            prod = 48'(env_mag) * 48'(coeff_cfg);
            env_mag = prod[plre_pkg::COEFF_WIDTH +: plre_pkg::SAMPLE_WIDTH];
        end
        if (env_mag > {1'b0, thr_cfg}) begin
            prod = 48'(mag) * 48'(thr_cfg);
            quot = plre_pkg::SAMPLE_WIDTH'(prod / 48'(env_mag));
            res.sample = neg ? (~quot + 1'b1) : quot;
        end
        res.engaged = engaged_st;
        return res;
    endfunction

    // Mostly magnitudes around the threshold, with the full range and the extremes mixed in.
    function automatic logic [plre_pkg::SAMPLE_WIDTH-1:0] random_sample(input int unsigned thr);
        int m;
        m = 0;
        case ($urandom_range(0, 9))
            0: return plre_pkg::SAMPLE_WIDTH'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return plre_pkg::SAMPLE_WIDTH'(FULL_POS);
                    1: return plre_pkg::SAMPLE_WIDTH'(FULL_MAG);
                    2: return '0;
                    3: return plre_pkg::SAMPLE_WIDTH'(1);
                    default: return '1;
                endcase
            end
            2, 3: m = int'(thr) + int'($urandom_range(0, 4)) - 2;
            4, 5, 6: m = int'($urandom_range(0, thr));
            7, 8: m = int'($urandom_range(thr, FULL_MAG));
            default: m = int'($urandom_range(0, FULL_MAG) >> $urandom_range(0, 23));
        endcase
        if (m < 0) m = 0;
        if (m > int'(FULL_MAG)) m = int'(FULL_MAG);
        if ($urandom_range(0, 1) != 0)
            return plre_pkg::SAMPLE_WIDTH'(-m);
        return (m == int'(FULL_MAG)) ? plre_pkg::SAMPLE_WIDTH'(FULL_POS)
                                     : plre_pkg::SAMPLE_WIDTH'(m);
    endfunction

    task automatic push_item(input logic [plre_pkg::SAMPLE_WIDTH-1:0] smp, input logic first);
        t_sample_item it;
        it.sample = smp;
        it.first = first;
        samples_to_send.insert(samples_to_send.size(), it);
    endtask

    // Tracks of random length: a first-of-track item opens most of them, and a stray
    // one now and then lands in the middle.
    task automatic push_tracks(input int count, input int unsigned thr);
        int pushed;
        int len;
        pushed = 0;
        while (pushed < count) begin
            len = $urandom_range(1, 80);
            for (int i = 0; i < len && pushed < count; i++) begin
                if (i == 0)
                    push_item(random_sample(thr), $urandom_range(0, 9) != 0);
                else
                    push_item(random_sample(thr), $urandom_range(0, 49) == 0);
                pushed++;
            end
        end
    endtask

    task automatic set_reg(input logic addr, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = plre_pkg::CFG_WIDTH'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_axis_tvalid || limited_pending.size() != 0)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_input
        t_sample_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = samples_to_send.pop_front();
                s_axis_tdata <= plre_pkg::TDATA_WIDTH'(nxt.sample);
                s_axis_tuser <= nxt.first;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the input side fill up and back-pressure the sender.
    always @(negedge i_clk) begin : drive_ready
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch
        t_limited got;
        t_limited want;
        in_fire = 1'b0;
        if (!i_rst_n) begin
            env_mag = '0;
            engaged_st = 1'b0;
            thr_cfg = plre_pkg::THR_RESET;
            coeff_cfg = plre_pkg::COEFF_RESET;
            limited_pending.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    plre_pkg::CFG_THRESHOLD:
                        thr_cfg = i_cfg_data[plre_pkg::THR_WIDTH-1:0];
                    plre_pkg::CFG_RELEASE:
                        coeff_cfg = i_cfg_data[plre_pkg::COEFF_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.sample = m_axis_tdata[plre_pkg::SAMPLE_WIDTH-1:0];
                got.engaged = m_axis_tuser;
                if (limited_pending.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected item, expected none, got sample_out %h engaged %b",
                             $time, got.sample, got.engaged);
                end else begin
                    want = limited_pending.pop_front();
                    if (got.sample !== want.sample) begin
                        mismatch_count++;
                        $display("%0t: sample_out expected %h, got %h",
                                 $time, want.sample, got.sample);
                    end
                    if (got.engaged !== want.engaged) begin
                        mismatch_count++;
                        $display("%0t: engaged expected %b, got %b",
                                 $time, want.engaged, got.engaged);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_fire = 1'b1;
                limited_pending.insert(limited_pending.size(),
                    limit_sample(s_axis_tdata[plre_pkg::SAMPLE_WIDTH-1:0], s_axis_tuser));
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_thr[8];
        int unsigned phase_coeff[8];
        phase_thr = '{1048576, 0, FULL_POS, 0, 524288, 1, 0, 1048576};
        phase_coeff = '{65522, 65535, 0, 0, 60000, 1, 65535, 65522};
        phase_thr[3] = $urandom_range(0, FULL_POS);
        phase_coeff[3] = $urandom_range(0, 65535);
        phase_thr[6] = $urandom_range(0, 4096);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: full scale, equal-to-threshold and just-above cases, track clears.
        push_item(plre_pkg::SAMPLE_WIDTH'(0), 1'b1);
        push_item(plre_pkg::SAMPLE_WIDTH'(FULL_POS), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(FULL_MAG), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(1048576), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-1048576), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(1048577), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-1048577), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(0), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(1), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-1), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(500000), 1'b1);
        push_item(plre_pkg::SAMPLE_WIDTH'(2000000), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-700000), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(100), 1'b0);
        wait_drained();

        // A zero threshold: any nonzero sample engages and the output goes to zero.
        set_reg(plre_pkg::CFG_THRESHOLD, 0);
        push_item(plre_pkg::SAMPLE_WIDTH'(0), 1'b1);
        push_item(plre_pkg::SAMPLE_WIDTH'(5), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-3), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(0), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(0), 1'b1);
        wait_drained();

        // Largest threshold: only the most negative sample lies above it.
        set_reg(plre_pkg::CFG_THRESHOLD, FULL_POS);
        push_item(plre_pkg::SAMPLE_WIDTH'(FULL_MAG), 1'b1);
        push_item(plre_pkg::SAMPLE_WIDTH'(FULL_POS), 1'b0);
        push_item(plre_pkg::SAMPLE_WIDTH'(-8388607), 1'b0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            set_reg(plre_pkg::CFG_THRESHOLD, phase_thr[ph]);
            set_reg(plre_pkg::CFG_RELEASE, phase_coeff[ph]);
            push_tracks(PHASE_ITEMS, phase_thr[ph]);
            if (ph == 0)
                hold_req = ~hold_req;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && limited_pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #18000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
